### sv/pfr_pkg.sv
// shared types and constants for the page framebuffer refresh block
// no dependencies
package pfr_pkg;

    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] HEADER_STEPS  = 8'd3;

    typedef struct packed {
        logic latch;
        logic clr_start;
        logic clr_step;
        logic draw_rd;
        logic draw_wr;
        logic tick_rd;
        logic tick_out;
    } pfr_cmd_t;

    typedef struct packed {
        logic in_range;
        logic clr_last;
    } pfr_stat_t;

endpackage

### sv/page_framebuffer_refresh.sv
// top level of the page framebuffer with byte-serial refresh stream
// depends on pfr_pkg, pfr_ctrl, pfr_datapath
//
//  channel   handshake          fields
//  request   start / busy       req_type, pixel_x, pixel_y, pixel_on
//  result    strobe (1 cycle)   out_byte, is_data, frame_end
//
// draw: read then write state before busy drops; out-of-range draw leaves the read state without access
// refresh tick: read state then output state, result strobe in the cycle busy drops
// clear: counter restarts from zero, one store entry per cycle on the single port
// after reset the same clearing pass over the whole store runs with busy high
// the result side cannot stall; each beat stands for one cycle only
module page_framebuffer_refresh #(
    parameter int PAGES = 8,
    parameter int WIDTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [6:0] pixel_x,
    input  logic [5:0] pixel_y,
    input  logic       pixel_on,
    output logic       strobe,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       frame_end
);

    pfr_pkg::pfr_cmd_t  cmd;
    pfr_pkg::pfr_stat_t stat;

    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    pfr_datapath #(
        .PAGES (PAGES),
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pixel_on  (pixel_on),
        .strobe    (strobe),
        .out_byte  (out_byte),
        .is_data   (is_data),
        .frame_end (frame_end)
    );

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result beat while busy");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == pfr_pkg::REQ_TICK) |=> ##2 strobe)
        else $error("refresh tick gave no result beat");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == pfr_pkg::REQ_CLEAR) |=> busy)
        else $error("clear did not hold off requests");

    a_end_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && frame_end) |-> is_data)
        else $error("frame end on a command beat");

endmodule

### sv/pfr_datapath.sv
// pixel store memory, refresh pointer, clear counter and result registers
// depends on pfr_pkg
module pfr_datapath #(
    parameter int PAGES = 8,
    parameter int WIDTH = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pfr_pkg::pfr_cmd_t cmd,
    output pfr_pkg::pfr_stat_t stat,
    input  logic [6:0]       pixel_x,
    input  logic [5:0]       pixel_y,
    input  logic             pixel_on,
    output logic             strobe,
    output logic [7:0]       out_byte,
    output logic             is_data,
    output logic             frame_end
);

    localparam int DEPTH = PAGES * WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;

    logic [6:0]    x_reg;
    logic [5:0]    y_reg;
    logic          on_reg;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0] page_reg, page_next;
    logic [7:0]    pos_reg, pos_next;

    logic          strobe_reg;
    logic [7:0]    out_byte_reg;
    logic          is_data_reg;
    logic          frame_end_reg;

    logic [11:0]   draw_full;
    logic [AW-1:0] draw_addr;
    logic [7:0]    col;
    logic [AW-1:0] tick_addr;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mask;
    logic [7:0]    wr_data;
    logic          mem_we;
    logic          mem_re;
    logic          pos_is_data;
    logic          last_col;
    logic          last_page;

    assign draw_full = 12'(y_reg[5:3]) * 12'(WIDTH) + 12'(x_reg);
    assign draw_addr = AW'(draw_full);
    assign pos_is_data = (pos_reg >= pfr_pkg::HEADER_STEPS);
    assign col = pos_is_data ? (pos_reg - pfr_pkg::HEADER_STEPS) : 8'd0;
    assign tick_addr = AW'(page_reg) * AW'(WIDTH) + AW'(col);
    assign mask = 8'd1 << y_reg[2:0];
    assign last_col = (col == 8'(WIDTH - 1));
    assign last_page = (page_reg == PW'(PAGES - 1));

    assign stat.in_range = ({1'b0, x_reg} < 8'(WIDTH)) && ({2'b00, y_reg} < 8'(8 * PAGES));
    assign stat.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));

    always_comb
    begin
        mem_addr = tick_addr;
        wr_data  = 8'd0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        if (cmd.clr_step)
        begin
            mem_addr = clr_cnt_reg;
            mem_we   = 1'b1;
        end
        else if (cmd.draw_rd)
        begin
            mem_addr = draw_addr;
            mem_re   = 1'b1;
        end
        else if (cmd.draw_wr)
        begin
            mem_addr = draw_addr;
            mem_we   = 1'b1;
            wr_data  = on_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
        end
        else if (cmd.tick_rd)
        begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg  <= pixel_x;
            y_reg  <= pixel_y;
            on_reg <= pixel_on;
        end
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_start)
        begin
            clr_cnt_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
    end

    always_comb
    begin
        page_next = page_reg;
        pos_next  = pos_reg;
        if (cmd.tick_out)
        begin
            if (pos_reg == 8'(WIDTH + 2))
            begin
                pos_next  = 8'd0;
                page_next = last_page ? '0 : page_reg + PW'(1);
            end
            else
            begin
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            page_reg    <= '0;
            pos_reg     <= 8'd0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            page_reg    <= page_next;
            pos_reg     <= pos_next;
            strobe_reg  <= cmd.tick_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_out)
        begin
            is_data_reg   <= pos_is_data;
            frame_end_reg <= pos_is_data && last_col && last_page;
            case (pos_reg)
                8'd0:    out_byte_reg <= pfr_pkg::CMD_PAGE_BASE | 8'(page_reg);
                8'd1:    out_byte_reg <= pfr_pkg::CMD_COL_LOW;
                8'd2:    out_byte_reg <= pfr_pkg::CMD_COL_HIGH;
                default: out_byte_reg <= rd_data_reg;
            endcase
        end
    end

    assign strobe    = strobe_reg;
    assign out_byte  = out_byte_reg;
    assign is_data   = is_data_reg;
    assign frame_end = frame_end_reg;

endmodule

### sv/pfr_ctrl.sv
// request sequencer: clear sweep, draw read-modify-write, refresh read and emit
// depends on pfr_pkg
module pfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         req_type,
    input  pfr_pkg::pfr_stat_t stat,
    output pfr_pkg::pfr_cmd_t  cmd,
    output logic               busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_TICK_RD,
        ST_TICK_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    case (req_type)
                        pfr_pkg::REQ_DRAW:  state_next = ST_DRAW_RD;
                        pfr_pkg::REQ_TICK:  state_next = ST_TICK_RD;
                        pfr_pkg::REQ_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW_RD:
            begin
                if (stat.in_range)
                begin
                    cmd.draw_rd = 1'b1;
                    state_next  = ST_DRAW_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW_WR:
            begin
                cmd.draw_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_TICK_RD:
            begin
                cmd.tick_rd = 1'b1;
                state_next  = ST_TICK_OUT;
            end
            ST_TICK_OUT:
            begin
                cmd.tick_out = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### test/page_framebuffer_refresh_tb.sv
// testbench for page_framebuffer_refresh: random draw, clear and refresh requests
// are predicted by a scoreboard that mirrors the store and the refresh pointer
// depends on pfr_pkg and page_framebuffer_refresh
module page_framebuffer_refresh_tb;

    localparam int PAGES = 8;
    localparam int WIDTH = 128;
    localparam int PAGE_BEATS = int'(pfr_pkg::HEADER_STEPS) + WIDTH;
    localparam int RANDOM_ITEMS = 532;
    localparam int SETTLE_CYCLES = PAGES * WIDTH + 16;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] value;
        logic       data_flag;
        logic       last_flag;
    } stream_beat_t;

    class framebuffer_scoreboard;
        bit [7:0]     shadow [PAGES][WIDTH];
        int           page_idx;
        int           step_idx;
        stream_beat_t awaited [$];
        int           errors;

        function new();
            clear_store();
            page_idx = 0;
            step_idx = 0;
            errors = 0;
        endfunction

        function void clear_store();
            foreach (shadow[p, c])
                shadow[p][c] = 8'h00;
        endfunction

        function void note_request(logic [1:0] kind, logic [6:0] x, logic [5:0] y, logic on);
            stream_beat_t beat;
            int           col;
            case (kind)
                pfr_pkg::REQ_DRAW:
                begin
                    if (int'(x) < WIDTH && int'(y) < 8 * PAGES)
                        shadow[y / 8][x][y % 8] = on;
                end
                pfr_pkg::REQ_TICK:
                begin
                    beat = '0;
                    if (step_idx == 0)
                        beat.value = pfr_pkg::CMD_PAGE_BASE | 8'(page_idx);
                    else if (step_idx == 1)
                        beat.value = pfr_pkg::CMD_COL_LOW;
                    else if (step_idx == 2)
                        beat.value = pfr_pkg::CMD_COL_HIGH;
                    else
                    begin
                        col = step_idx - int'(pfr_pkg::HEADER_STEPS);
                        beat.value = shadow[page_idx][col];
                        beat.data_flag = 1'b1;
                        beat.last_flag = (col == WIDTH - 1 && page_idx == PAGES - 1);
                    end
                    awaited.push_back(beat);
                    if (step_idx + 1 >= PAGE_BEATS)
                    begin
                        step_idx = 0;
                        page_idx = (page_idx + 1 >= PAGES) ? 0 : page_idx + 1;
                    end
                    else
                        step_idx++;
                end
                pfr_pkg::REQ_CLEAR:
                    clear_store();
                default:
                    ;
            endcase
        endfunction

        function void check_beat(logic [7:0] value, logic data_flag, logic last_flag);
            stream_beat_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %02h %0b %0b",
                         $time, value, data_flag, last_flag);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
                errors++;
            end
            if (data_flag !== want.data_flag)
            begin
                $display("%0t: is_data expected %0b actual %0b", $time, want.data_flag, data_flag);
                errors++;
            end
            if (last_flag !== want.last_flag)
            begin
                $display("%0t: frame_end expected %0b actual %0b", $time, want.last_flag, last_flag);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void report_leftovers();
            if (awaited.size() != 0)
            begin
                $display("%0t: beats expected %0d more, actual none", $time, awaited.size());
                errors += awaited.size();
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] req_type = pfr_pkg::REQ_DRAW;
    logic [6:0] pixel_x = '0;
    logic [5:0] pixel_y = '0;
    logic       pixel_on = 1'b0;
    logic       strobe;
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;

    framebuffer_scoreboard sb = new();

    page_framebuffer_refresh #(
        .PAGES(PAGES),
        .WIDTH(WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .pixel_on(pixel_on),
        .strobe(strobe),
        .out_byte(out_byte),
        .is_data(is_data),
        .frame_end(frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_beat(out_byte, is_data, frame_end);
    end

    task automatic send_request(input logic [1:0] kind, input logic [6:0] x,
                                input logic [5:0] y, input logic on);
        start <= 1'b1;
        req_type <= kind;
        pixel_x <= x;
        pixel_y <= y;
        pixel_on <= on;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(kind, x, y, on);
    endtask

    task automatic rest(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int         sent;
        int         roll;
        int         idle_pct;
        int         phase;
        int         last_phase;
        logic [1:0] kind;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pixel extremes and bit positions
        send_request(pfr_pkg::REQ_DRAW, 7'd0, 6'd0, 1'b1);
        send_request(pfr_pkg::REQ_DRAW, 7'd127, 6'd63, 1'b1);
        send_request(pfr_pkg::REQ_DRAW, 7'd127, 6'd0, 1'b1);
        send_request(pfr_pkg::REQ_DRAW, 7'd0, 6'd63, 1'b1);
        send_request(pfr_pkg::REQ_DRAW, 7'd1, 6'd7, 1'b1);
        send_request(pfr_pkg::REQ_DRAW, 7'd1, 6'd7, 1'b0);
        send_request(pfr_pkg::REQ_DRAW, 7'd1, 6'd6, 1'b1);
        // three command bytes and the first data bytes
        repeat (5) send_request(pfr_pkg::REQ_TICK, 7'h7F, 6'h3F, 1'b1);
        // clear in the middle of a page
        send_request(pfr_pkg::REQ_DRAW, 7'd2, 6'd3, 1'b1);
        send_request(pfr_pkg::REQ_CLEAR, 7'h55, 6'h2A, 1'b1);
        send_request(pfr_pkg::REQ_TICK, 7'd0, 6'd0, 1'b0);
        send_request(pfr_pkg::REQ_DRAW, 7'd127, 6'd63, 1'b1);
        send_request(pfr_pkg::REQ_DRAW, 7'd0, 6'd56, 1'b1);
        send_request(REQ_UNUSED, 7'h7F, 6'h3F, 1'b1);
        drain();

        sent = 0;
        last_phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase = (sent < RANDOM_ITEMS / 3) ? 0 : (sent < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
            if (phase != last_phase)
                drain();
            last_phase = phase;
            idle_pct = (phase == 0) ? 7 : (phase == 1) ? 55 : 0;

            roll = $urandom_range(0, 99);
            if (roll < 68)
                kind = pfr_pkg::REQ_TICK;
            else if (roll < 96)
                kind = pfr_pkg::REQ_DRAW;
            else if (roll < 98)
                kind = pfr_pkg::REQ_CLEAR;
            else
                kind = REQ_UNUSED;
            send_request(kind, 7'($urandom), 6'($urandom), 1'($urandom));
            sent++;
            if ($urandom_range(0, 99) < idle_pct)
                rest($urandom_range(1, 4));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.report_leftovers();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### page_framebuffer_refresh.f
sv/pfr_pkg.sv
sv/pfr_datapath.sv
sv/pfr_ctrl.sv
sv/page_framebuffer_refresh.sv
test/page_framebuffer_refresh_tb.sv
